// ----- rtl/ipc_pkg.sv -----
// Shared constants and types for the inverse Park/Clarke PWM duty block.
package ipc_pkg;

  localparam int CORDIC_STEPS = 15;
  localparam int XW = 34;
  localparam int ZW = 18;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
  localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(16384);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(32768);

  localparam logic signed [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    ZW'(8192), ZW'(4836), ZW'(2555), ZW'(1297), ZW'(651), ZW'(326), ZW'(163),
    ZW'(81), ZW'(41), ZW'(20), ZW'(10), ZW'(5), ZW'(3), ZW'(1), ZW'(1)
  };

  localparam logic REG_SUPPLY = 1'b0;
  localparam logic REG_CAP = 1'b1;

  typedef logic signed [XW-1:0] cordic_t;
  typedef logic signed [ZW-1:0] angle_t;
  typedef logic signed [31:0] phase_v_t;

endpackage

// ----- rtl/ipc_cordic.sv -----
// Pipelined rotation-mode CORDIC giving cosine and sine in Q1.30.
module ipc_cordic import ipc_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  angle_t          z_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            vld_o,
  output cordic_t         x_o,
  output cordic_t         y_o,
  output logic [SB_W-1:0] sb_o
);

  logic            vld_r [CORDIC_STEPS];
  cordic_t         x_r   [CORDIC_STEPS];
  cordic_t         y_r   [CORDIC_STEPS];
  angle_t          z_r   [CORDIC_STEPS];
  logic [SB_W-1:0] sb_r  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    cordic_t         x_in, y_in, x_nxt, y_nxt;
    angle_t          z_in, z_nxt;
    logic            vld_in;
    logic [SB_W-1:0] sb_in;

    if (i == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = z_i;
      assign vld_in = vld_i;
      assign sb_in = sb_i;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign vld_in = vld_r[i-1];
      assign sb_in = sb_r[i-1];
    end

    always_comb begin
      if (z_in >= 0) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - ATAN_TURNS[i];
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        sb_r[i] <= sb_in;
      end
    end
  end

  assign vld_o = vld_r[CORDIC_STEPS-1];
  assign x_o = x_r[CORDIC_STEPS-1];
  assign y_o = y_r[CORDIC_STEPS-1];
  assign sb_o = sb_r[CORDIC_STEPS-1];

endmodule

// ----- rtl/ipc_duty.sv -----
// Per-phase clamp, scale and pipelined restoring divide to a compare count.
module ipc_duty import ipc_pkg::*; #(
  parameter int PWM_PERIOD = 4800
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic        tag_i,
  input  phase_v_t    u_i,
  input  logic [15:0] supply_i,
  input  logic [15:0] cap_i,
  output logic        vld_o,
  output logic        tag_o,
  output logic [12:0] duty_o
);

  localparam int PW = $clog2(PWM_PERIOD + 1);
  localparam int NW = 24 + PW;
  localparam logic [PW-1:0] PERIOD = PW'(PWM_PERIOD);

  logic [23:0] vs;
  logic [23:0] ucl_nxt;
  assign vs = {supply_i, 8'd0};

  always_comb begin
    if (u_i < 0) begin
      ucl_nxt = '0;
    end else if (u_i > $signed({8'd0, cap_i, 8'd0})) begin
      ucl_nxt = {cap_i, 8'd0};
    end else begin
      ucl_nxt = u_i[23:0];
    end
  end

  // clamp stage
  logic        c_vld_r, c_tag_r, c_sat_r, c_zero_r;
  logic [23:0] c_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= vld_i;
    end
    if (en) begin
      c_tag_r <= tag_i;
      c_u_r <= ucl_nxt;
      c_sat_r <= ucl_nxt >= vs;
      c_zero_r <= supply_i == 16'd0;
    end
  end

  // multiply stage and divider stages
  logic          d_vld_r  [PW+1];
  logic          d_tag_r  [PW+1];
  logic          d_sat_r  [PW+1];
  logic          d_zero_r [PW+1];
  logic [23:0]   d_rem_r  [PW+1];
  logic [PW-1:0] d_low_r  [PW+1];
  logic [PW-1:0] d_q_r    [PW+1];

  logic [NW-1:0] num;
  assign num = c_u_r * PERIOD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r[0] <= 1'b0;
    end else if (en) begin
      d_vld_r[0] <= c_vld_r;
    end
    if (en) begin
      d_tag_r[0] <= c_tag_r;
      d_sat_r[0] <= c_sat_r;
      d_zero_r[0] <= c_zero_r;
      d_rem_r[0] <= num[NW-1:PW];
      d_low_r[0] <= num[PW-1:0];
      d_q_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < PW; k++) begin : g_div
    logic [24:0]   trial;
    logic          take;
    logic [24:0]   diff;
    assign trial = {d_rem_r[k], d_low_r[k][PW-1]};
    assign take = trial >= {1'b0, vs};
    assign diff = trial - {1'b0, vs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        d_vld_r[k+1] <= d_vld_r[k];
      end
      if (en) begin
        d_tag_r[k+1] <= d_tag_r[k];
        d_sat_r[k+1] <= d_sat_r[k];
        d_zero_r[k+1] <= d_zero_r[k];
        d_rem_r[k+1] <= take ? diff[23:0] : trial[23:0];
        d_low_r[k+1] <= d_low_r[k] << 1;
        d_q_r[k+1] <= {d_q_r[k][PW-2:0], take};
      end
    end
  end

  // select stage
  logic          f_vld_r, f_tag_r;
  logic [PW-1:0] f_d_r;
  logic [PW-1:0] f_d_nxt;
  logic [PW+12:0] f_ext;

  always_comb begin
    priority if (d_zero_r[PW]) begin
      f_d_nxt = '0;
    end else if (d_sat_r[PW]) begin
      f_d_nxt = PERIOD;
    end else begin
      f_d_nxt = d_q_r[PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= d_vld_r[PW];
    end
    if (en) begin
      f_tag_r <= d_tag_r[PW];
      f_d_r <= f_d_nxt;
    end
  end

  assign f_ext = {13'd0, f_d_r};
  assign vld_o = f_vld_r;
  assign tag_o = f_tag_r;
  assign duty_o = f_ext[12:0];

endmodule

// ----- rtl/inverse_park_clarke_pwm_duty.sv -----
// Top level: inverse Park/Clarke transform with sinusoidal PWM duty output.
//
// Input channel (in_valid/in_ready) takes a motor select, a signed Q8.8
// quadrature voltage and a 16-bit electrical angle. Output channel
// (out_valid/out_ready) returns the motor select and three compare counts.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes the
// supply voltage (index 0) and the phase voltage cap (index 1).
//
// One item can be taken every cycle while in_ready is high. The pipeline is
// one input stage, 15 CORDIC stages, four transform stages, clamp and
// multiply stages, one divider stage per quotient bit, a select stage and
// the output register.
//
// Reset empties the pipeline and loads supply 12 V and cap 8 V.
// When the receiver stalls, the output register holds its result and a
// skid register catches the next one; in_ready drops while the skid is
// full, and the whole pipeline holds in place.
module inverse_park_clarke_pwm_duty import ipc_pkg::*; #(
  parameter int PWM_PERIOD = 4800
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_motor_select,
  input  logic signed [15:0] in_torque_voltage,
  input  logic [15:0]        in_elec_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_motor_echo,
  output logic [12:0]        out_duty_a,
  output logic [12:0]        out_duty_b,
  output logic [12:0]        out_duty_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef struct packed {
    logic        sel;
    logic [12:0] a;
    logic [12:0] b;
    logic [12:0] c;
  } result_t;

  logic [15:0] supply_r, cap_r;
  logic        pipe_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= 16'd3072;
      cap_r <= 16'd2048;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SUPPLY: supply_r <= cfg_data;
        REG_CAP:    cap_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // input stage: fold angle into a quarter turn
  angle_t z_nxt, z_raw;
  logic   flip_nxt;

  always_comb begin
    z_raw = angle_t'($signed(in_elec_angle));
    priority if (z_raw > QUARTER_TURN) begin
      z_nxt = z_raw - HALF_TURN;
      flip_nxt = 1'b1;
    end else if (z_raw < -QUARTER_TURN) begin
      z_nxt = z_raw + HALF_TURN;
      flip_nxt = 1'b1;
    end else begin
      z_nxt = z_raw;
      flip_nxt = 1'b0;
    end
  end

  logic               i_vld_r, i_sel_r, i_flip_r;
  logic signed [15:0] i_uq_r;
  angle_t             i_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (pipe_en) begin
      i_vld_r <= in_valid;
    end
    if (pipe_en) begin
      i_sel_r <= in_motor_select;
      i_flip_r <= flip_nxt;
      i_uq_r <= in_torque_voltage;
      i_z_r <= z_nxt;
    end
  end

  logic        k_vld;
  cordic_t     k_x, k_y;
  logic [17:0] k_sb;

  ipc_cordic #(.SB_W(18)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .vld_i (i_vld_r),
    .z_i   (i_z_r),
    .sb_i  ({i_sel_r, i_flip_r, i_uq_r}),
    .vld_o (k_vld),
    .x_o   (k_x),
    .y_o   (k_y),
    .sb_o  (k_sb)
  );

  // m1: Uq times cos and sin
  logic               m1_vld_r, m1_sel_r, m1_flip_r;
  logic signed [49:0] m1_ps_r, m1_pc_r;
  logic signed [15:0] k_uq;
  assign k_uq = k_sb[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m1_vld_r <= k_vld;
    end
    if (pipe_en) begin
      m1_sel_r <= k_sb[17];
      m1_flip_r <= k_sb[16];
      m1_ps_r <= k_uq * k_y;
      m1_pc_r <= k_uq * k_x;
    end
  end

  // m2: signs and rounding to Q.16
  logic               m2_vld_r, m2_sel_r;
  logic signed [27:0] m2_alpha_r, m2_beta_r;
  logic signed [49:0] ta, tb;

  always_comb begin
    ta = (m1_flip_r ? m1_ps_r : -m1_ps_r) + 50'sd2097152;
    tb = (m1_flip_r ? -m1_pc_r : m1_pc_r) + 50'sd2097152;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m2_vld_r <= m1_vld_r;
    end
    if (pipe_en) begin
      m2_sel_r <= m1_sel_r;
      m2_alpha_r <= ta[49:22];
      m2_beta_r <= tb[49:22];
    end
  end

  // m3: beta times sqrt(3)
  logic               m3_vld_r, m3_sel_r;
  logic signed [27:0] m3_alpha_r;
  logic signed [59:0] m3_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m3_vld_r <= m2_vld_r;
    end
    if (pipe_en) begin
      m3_sel_r <= m2_sel_r;
      m3_alpha_r <= m2_alpha_r;
      m3_prod_r <= m2_beta_r * SQRT3_Q30;
    end
  end

  // m4: phase voltages
  logic               m4_vld_r, m4_sel_r;
  phase_v_t           m4_ua_r, m4_ub_r, m4_uc_r;
  logic signed [59:0] ts;
  phase_v_t           s3b, al, half, dbv, dcv;

  always_comb begin
    ts = m3_prod_r + 60'sd536870912;
    s3b = phase_v_t'($signed(ts[59:30]));
    al = phase_v_t'(m3_alpha_r);
    half = $signed({9'd0, supply_r, 7'd0});
    dbv = s3b - al;
    dcv = -(al + s3b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m4_vld_r <= m3_vld_r;
    end
    if (pipe_en) begin
      m4_sel_r <= m3_sel_r;
      m4_ua_r <= al + half;
      m4_ub_r <= (dbv >>> 1) + half;
      m4_uc_r <= (dcv >>> 1) + half;
    end
  end

  logic        p_vld, p_sel;
  logic [12:0] p_a, p_b, p_c;
  result_t     p_res;

  ipc_duty #(.PWM_PERIOD(PWM_PERIOD)) u_duty_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .vld_i    (m4_vld_r),
    .tag_i    (m4_sel_r),
    .u_i      (m4_ua_r),
    .supply_i (supply_r),
    .cap_i    (cap_r),
    .vld_o    (p_vld),
    .tag_o    (p_sel),
    .duty_o   (p_a)
  );

  ipc_duty #(.PWM_PERIOD(PWM_PERIOD)) u_duty_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .vld_i    (m4_vld_r),
    .tag_i    (m4_sel_r),
    .u_i      (m4_ub_r),
    .supply_i (supply_r),
    .cap_i    (cap_r),
    .vld_o    (),
    .tag_o    (),
    .duty_o   (p_b)
  );

  ipc_duty #(.PWM_PERIOD(PWM_PERIOD)) u_duty_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .vld_i    (m4_vld_r),
    .tag_i    (m4_sel_r),
    .u_i      (m4_uc_r),
    .supply_i (supply_r),
    .cap_i    (cap_r),
    .vld_o    (),
    .tag_o    (),
    .duty_o   (p_c)
  );

  assign p_res = {p_sel, p_a, p_b, p_c};

  // output register and skid
  logic    out_vld_r, skid_vld_r;
  result_t out_res_r, skid_res_r;
  logic    out_free, p_leave;

  assign pipe_en = !skid_vld_r;
  assign in_ready = pipe_en;
  assign out_free = out_ready || !out_vld_r;
  assign p_leave = pipe_en && p_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_r <= skid_vld_r || p_leave;
        skid_vld_r <= 1'b0;
      end else if (p_leave) begin
        skid_vld_r <= 1'b1;
      end
    end
    if (out_free) begin
      out_res_r <= skid_vld_r ? skid_res_r : p_res;
    end else if (p_leave) begin
      skid_res_r <= p_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_motor_echo = out_res_r.sel;
  assign out_duty_a = out_res_r.a;
  assign out_duty_b = out_res_r.b;
  assign out_duty_c = out_res_r.c;

endmodule

// ----- rtl/ipc_checker.sv -----
// Port-level checks for the inverse Park/Clarke PWM duty block, with bind.
module ipc_checker #(
  parameter int PWM_PERIOD = 4800
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_motor_echo,
  input logic [12:0] out_duty_a,
  input logic [12:0] out_duty_b,
  input logic [12:0] out_duty_c,
  input logic        cfg_ready
);

  localparam logic [12:0] LIMIT = (PWM_PERIOD > 8191) ? 13'h1FFF : 13'(PWM_PERIOD);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_a)
      && $stable(out_duty_b) && $stable(out_duty_c) && $stable(out_motor_echo))
    else $error("stalled result changed");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_a <= LIMIT && out_duty_b <= LIMIT && out_duty_c <= LIMIT)
    else $error("duty above period");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind inverse_park_clarke_pwm_duty ipc_checker #(.PWM_PERIOD(PWM_PERIOD)) u_ipc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_motor_echo (out_motor_echo),
  .out_duty_a     (out_duty_a),
  .out_duty_b     (out_duty_b),
  .out_duty_c     (out_duty_c),
  .cfg_ready      (cfg_ready)
);

// ----- sim/inverse_park_clarke_pwm_duty_tb.sv -----
// Testbench for the inverse Park/Clarke PWM duty block: predicts duties and checks them.
`timescale 1ns / 1ps
module inverse_park_clarke_pwm_duty_tb;
  import ipc_pkg::*;

  localparam int PERIOD_COUNT = 4800;
  localparam int LATENCY = 24 + $clog2(PERIOD_COUNT + 1);

  typedef struct packed {
    logic        sel;
    logic [15:0] uq;
    logic [15:0] angle;
  } command_t;

  typedef struct packed {
    logic        sel;
    logic [12:0] da;
    logic [12:0] db;
    logic [12:0] dc;
  } duties_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_motor_select = 1'b0;
  logic signed [15:0] in_torque_voltage = '0;
  logic [15:0] in_elec_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_motor_echo;
  logic [12:0] out_duty_a, out_duty_b, out_duty_c;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_SUPPLY;
  logic [15:0] cfg_data = '0;

  inverse_park_clarke_pwm_duty dut (.*);

  always #5 clk = ~clk;

  logic [15:0] supply_v = 16'd3072;
  logic [15:0] cap_v = 16'd2048;
  command_t pending_cmds[$];
  duties_t expected_duties[$];
  int failures = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;
  bit stream_on = 1'b0;
  bit flood = 1'b0;
  bit in_took = 1'b0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [12:0] phase_to_duty(longint u);
    longint cap_q, vs_q, d;
    cap_q = longint'(cap_v) << 8;
    vs_q = longint'(supply_v) << 8;
    if (u < 0) u = 0;
    if (u > cap_q) u = cap_q;
    if (vs_q <= 0) return '0;
    if (u >= vs_q) d = PERIOD_COUNT;
    else d = (u * PERIOD_COUNT) / vs_q;
    return d[12:0];
  endfunction

  function automatic duties_t predict_duties(command_t c);
    longint x, y, dx, dy, z, s, co, uq, alpha, beta, s3b, half;
    bit flip;
    duties_t r;
    int atan_lut[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
    z = c.angle;
    flip = 1'b0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768; flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768; flip = 1'b1;
    end
    x = 652032874; y = 0;
    for (int i = 0; i < 15; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    co = flip ? -x : x;
    s = flip ? -y : y;
    uq = longint'($signed(c.uq));
    alpha = fshift(-(uq * s) + (64'sd1 << 21), 22);
    beta = fshift(uq * co + (64'sd1 << 21), 22);
    s3b = fshift(beta * 64'sd1859775393 + (64'sd1 << 29), 30);
    half = longint'(supply_v) << 7;
    r.sel = c.sel;
    r.da = phase_to_duty(alpha + half);
    r.db = phase_to_duty(fshift(s3b - alpha, 1) + half);
    r.dc = phase_to_duty(fshift(-(alpha + s3b), 1) + half);
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        in_valid <= 1'b0;
      end
      if (!in_valid || in_took) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_on && pending_cmds.size() > 0) begin
          in_valid <= 1'b1;
          {in_motor_select, in_torque_voltage, in_elec_angle} <= pending_cmds.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = flood ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) || flood;
      end
    end
  end

  always @(posedge clk) begin
    in_took = rst_n && in_valid && in_ready;
    if (in_took) begin
      expected_duties.push_back(predict_duties({in_motor_select, in_torque_voltage,
                                                in_elec_angle}));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_duties.size() == 0) begin
        $error("unexpected transfer");
        failures++;
      end else begin
        duties_t e;
        e = expected_duties.pop_front();
        if (out_motor_echo !== e.sel) begin
          $error("motor_echo exp %0d got %0d", e.sel, out_motor_echo); failures++;
        end
        if (out_duty_a !== e.da) begin
          $error("duty_a exp %0d got %0d", e.da, out_duty_a); failures++;
        end
        if (out_duty_b !== e.db) begin
          $error("duty_b exp %0d got %0d", e.db, out_duty_b); failures++;
        end
        if (out_duty_c !== e.dc) begin
          $error("duty_c exp %0d got %0d", e.dc, out_duty_c); failures++;
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SUPPLY) supply_v = val;
    else cap_v = val;
  endtask

  task automatic drain;
    while (pending_cmds.size() > 0 || in_valid || expected_duties.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic add_cmd(logic sel, logic [15:0] uq, logic [15:0] ang);
    pending_cmds.push_back({sel, uq, ang});
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: add_cmd($urandom_range(0, 1), $urandom, $urandom);
        1: add_cmd($urandom_range(0, 1), $urandom_range(0, 4095) - 2048, $urandom);
        2: add_cmd($urandom_range(0, 1), $urandom_range(0, 1) ? 16'h8000 : 16'h7fff,
                   $urandom);
        default: add_cmd($urandom_range(0, 1), $urandom_range(0, 2047) - 1024,
                         $urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 3) - 1);
      endcase
    end
  endtask

  initial begin
    logic [15:0] sup_set[6] = '{16'd3072, 16'd1, 16'd65535, 16'd0, 16'd1500, 16'd40000};
    logic [15:0] cap_set[6] = '{16'd2048, 16'd65535, 16'd0, 16'd4096, 16'd30000, 16'd65535};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    add_cmd(1'b0, 16'h0000, 16'h0000);
    add_cmd(1'b1, 16'h7fff, 16'h0000);
    add_cmd(1'b0, 16'h8000, 16'h0000);
    add_cmd(1'b1, 16'h0600, 16'h4000);
    add_cmd(1'b0, 16'h0600, 16'h4001);
    add_cmd(1'b1, 16'h0600, 16'h8000);
    add_cmd(1'b0, 16'h0600, 16'hc000);
    add_cmd(1'b1, 16'hfa00, 16'hbfff);
    add_cmd(1'b0, 16'h7fff, 16'hffff);
    add_cmd(1'b1, 16'h8000, 16'h5555);
    add_cmd(1'b0, 16'h1000, 16'haaaa);
    add_cmd(1'b1, 16'hffff, 16'h2000);
    stream_on = 1'b1;
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SUPPLY, sup_set[p]);
      write_reg(REG_CAP, cap_set[p]);
      add_random(p == 0 ? 300 : 80);
      if (p == 2) begin
        flood = 1'b1;
        hold_off = 200;
        while (hold_off > 0) @(posedge clk);
        flood = 1'b0;
      end
      drain();
    end
    write_reg(REG_SUPPLY, 16'd3072);
    write_reg(REG_CAP, 16'd2048);
    add_random(40);
    drain();
    if (failures == 0) $display("inverse_park_clarke_pwm_duty_tb OK");
    else $display("inverse_park_clarke_pwm_duty_tb NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("inverse_park_clarke_pwm_duty_tb NOT OK");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/ipc_pkg.sv
rtl/ipc_cordic.sv
rtl/ipc_duty.sv
rtl/inverse_park_clarke_pwm_duty.sv
rtl/ipc_checker.sv
sim/inverse_park_clarke_pwm_duty_tb.sv
